@@ hw/rtl/sactc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sactc_pkg
// Shared types, constants and replacement tables of the cache tag controller.
// ---------------------------------------------------------------------------
package sactc_pkg;

	localparam int WAYS      = 8;
	localparam int SETS      = 64;
	localparam int ADDR_BITS = 32;
	localparam int SET_W     = $clog2(SETS);
	localparam int WAY_W     = 3;
	localparam int AGE_W     = 3;
	localparam int TREE_W    = 7;
	localparam int TAG_W     = ADDR_BITS - SET_W;
	localparam int SHIFT_W   = 3;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic [1:0] CFG_POLICY         = 2'd0;
	localparam logic [1:0] CFG_LINE_SHIFT     = 2'd1;
	localparam logic [1:0] CFG_THRU_MODE      = 2'd2;
	localparam logic [1:0] CFG_WRITE_ALLOCATE = 2'd3;
	localparam int         CFG_IDX_W          = 2;
	localparam int         CFG_DATA_W         = 3;

	localparam logic REQ_WRITE = 1'b1;
	localparam logic POL_TREE  = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
		logic             allocated;
		logic             line_fill;
		logic             dirty_writeback;
		logic             memory_write;
	} rsp_t;

	typedef struct packed {
		logic               policy;
		logic [SHIFT_W-1:0] line_shift;
		logic               thru_mode;
		logic               write_allocate;
	} cfg_t;

	// one classified access between front and back
	typedef struct packed {
		logic             is_write;
		logic [SET_W-1:0] set;
		logic [TAG_W-1:0] tag;
	} qent_t;

	// one set's state, kept as a single memory row
	typedef struct packed {
		logic [TREE_W-1:0]            tree;
		logic [WAYS-1:0][AGE_W-1:0]   ages;
		logic [WAYS-1:0]              dirty;
		logic [WAYS-1:0]              valid;
		logic [WAYS-1:0][TAG_W-1:0]   tags;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	localparam logic [7:0][TREE_W-1:0] PATH_MASK = {
		7'b1010001, 7'b1010001, 7'b1010010, 7'b1010010,
		7'b1100100, 7'b1100100, 7'b1101000, 7'b1101000
	};
	localparam logic [7:0][TREE_W-1:0] PATH_VAL = {
		7'b1010001, 7'b1010000, 7'b1000010, 7'b1000000,
		7'b0100100, 7'b0100000, 7'b0001000, 7'b0000000
	};

endpackage

@@ hw/rtl/sactc_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sactc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sactc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/sactc_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sactc_front
// Accepts accesses, splits the address into set and tag, and queues them.
// ---------------------------------------------------------------------------
module sactc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  sactc_pkg::req_t                     in_data,
	input  logic [sactc_pkg::SHIFT_W-1:0]       line_shift,
	output logic                                q_valid,
	output sactc_pkg::qent_t                    q_head,
	input  logic                                q_pop
);

	sactc_pkg::qent_t                  ent_q [sactc_pkg::QDEPTH];
	logic [sactc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [sactc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [sactc_pkg::QCNT_W-1:0]      cnt_q;
	logic                              push;
	logic [sactc_pkg::ADDR_BITS-1:0]   line_addr;
	sactc_pkg::qent_t                  new_ent;

	assign in_ready = (cnt_q != sactc_pkg::QCNT_W'(sactc_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_head   = ent_q[rd_ptr_q];

	always_comb begin
		line_addr         = in_data.address >> line_shift;
		new_ent.is_write  = (in_data.req_type == sactc_pkg::REQ_WRITE);
		new_ent.set       = line_addr[sactc_pkg::SET_W-1:0];
		new_ent.tag       = line_addr[sactc_pkg::ADDR_BITS-1:sactc_pkg::SET_W];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/sactc_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sactc_back
// Reads one set's row, resolves hit and victim, writes the row back, and
// holds the result in an output register.
// ---------------------------------------------------------------------------
module sactc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sactc_pkg::cfg_t      cfg,
	input  logic                 q_valid,
	input  sactc_pkg::qent_t     q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sactc_pkg::rsp_t      out_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic                            state_q;
	sactc_pkg::qent_t                ent_q;
	logic [sactc_pkg::SETS-1:0]      row_vld_q;
	logic                            out_valid_q;
	sactc_pkg::rsp_t                 out_q;

	logic                            slot_free;
	logic                            look;
	logic [sactc_pkg::ROW_W-1:0]     rdata;
	sactc_pkg::row_t                 cur;
	sactc_pkg::row_t                 nxt;
	sactc_pkg::row_t                 rst_row;
	logic [sactc_pkg::WAYS-1:0]      match;
	logic                            found;
	logic [sactc_pkg::WAY_W-1:0]     hit_way;
	logic [sactc_pkg::WAY_W-1:0]     victim;
	logic [sactc_pkg::AGE_W-1:0]     best;
	logic                            tree_mode;
	logic                            alloc;
	logic                            touch;
	logic [sactc_pkg::WAY_W-1:0]     w;
	logic [sactc_pkg::AGE_W-1:0]     a;
	sactc_pkg::rsp_t                 rsp;

	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && slot_free;
	assign look      = (state_q == ST_LOOK);
	assign tree_mode = (cfg.policy == sactc_pkg::POL_TREE) && (sactc_pkg::WAYS == 8);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	sactc_ram #(
		.WIDTH(sactc_pkg::ROW_W),
		.DEPTH(sactc_pkg::SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (look),
		.waddr (ent_q.set),
		.wdata (nxt),
		.re    (q_pop),
		.raddr (q_head.set),
		.rdata (rdata)
	);

	always_comb begin
		rst_row = sactc_pkg::row_t'(rdata);
		rst_row.tree  = '0;
		rst_row.dirty = '0;
		rst_row.valid = '0;
		for (int j = 0; j < sactc_pkg::WAYS; j++) begin
			rst_row.ages[j] = sactc_pkg::AGE_W'(j);
		end
		// a set never written since reset reads as its reset state
		cur = row_vld_q[ent_q.set] ? sactc_pkg::row_t'(rdata) : rst_row;

		for (int j = 0; j < sactc_pkg::WAYS; j++) begin
			match[j] = cur.valid[j] && (cur.tags[j] == ent_q.tag);
		end
		found   = (match != '0);
		hit_way = '0;
		for (int j = sactc_pkg::WAYS - 1; j >= 0; j--) begin
			if (match[j]) begin
				hit_way = sactc_pkg::WAY_W'(j);
			end
		end

		victim = '0;
		best   = '0;
		if (tree_mode) begin
			for (int j = 7; j >= 0; j--) begin
				if ((cur.tree & sactc_pkg::PATH_MASK[j]) == sactc_pkg::PATH_VAL[j]) begin
					victim = sactc_pkg::WAY_W'(j);
				end
			end
		end else begin
			for (int j = 0; j < sactc_pkg::WAYS; j++) begin
				if (cur.ages[j] > best) begin
					best   = cur.ages[j];
					victim = sactc_pkg::WAY_W'(j);
				end
			end
		end

		alloc = !found && (!ent_q.is_write || cfg.write_allocate);
		touch = found || alloc;
		w     = found ? hit_way : (alloc ? victim : '0);

		nxt = cur;
		rsp = '0;
		rsp.hit       = found;
		rsp.way       = w;
		rsp.allocated = alloc;
		rsp.line_fill = alloc;
		if (alloc) begin
			rsp.dirty_writeback = cur.valid[w] && cur.dirty[w];
			nxt.tags[w]  = ent_q.tag;
			nxt.valid[w] = 1'b1;
			nxt.dirty[w] = 1'b0;
		end
		if (touch && ent_q.is_write) begin
			if (cfg.thru_mode) begin
				rsp.memory_write = 1'b1;
			end else begin
				nxt.dirty[w] = 1'b1;
			end
		end
		if (!touch) begin
			rsp.memory_write = 1'b1;
		end

		a = cur.ages[w];
		if (touch) begin
			if (tree_mode) begin
				nxt.tree = (cur.tree & ~sactc_pkg::PATH_MASK[w])
					| (sactc_pkg::PATH_VAL[w] ^ sactc_pkg::PATH_MASK[w]);
			end else begin
				for (int j = 0; j < sactc_pkg::WAYS; j++) begin
					if (cur.ages[j] < a) begin
						nxt.ages[j] = cur.ages[j] + 1'b1;
					end
				end
				nxt.ages[w] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_head;
		end
		if (look) begin
			out_q <= rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (look) begin
				row_vld_q[ent_q.set] <= 1'b1;
				out_valid_q          <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/set_assoc_cache_tag_controller_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_controller_unit
// Tag and state controller of an 8-way set-associative cache.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_data  (req_type, address)
//   out      out_valid / out_ready out_data (hit, way, flags)
//   cfg      cfg_we                cfg_index, cfg_data
//
// In the back end each access first reads the set's row from the row RAM,
// then resolves hit and victim and writes the row back.
// Unstalled, an item passes the queue, entry register and output register.
// A 2-entry queue lets the front accept while the back is busy.
// Reset clears per-set valid flags at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module set_assoc_cache_tag_controller_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  sactc_pkg::req_t                      in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output sactc_pkg::rsp_t                      out_data,
	input  logic                                 cfg_we,
	input  logic [sactc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sactc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	sactc_pkg::cfg_t  cfg_q;
	logic             q_valid;
	logic             q_pop;
	sactc_pkg::qent_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy         <= 1'b0;
			cfg_q.line_shift     <= 3'd2;
			cfg_q.thru_mode      <= 1'b0;
			cfg_q.write_allocate <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sactc_pkg::CFG_POLICY:         cfg_q.policy         <= cfg_data[0];
				sactc_pkg::CFG_LINE_SHIFT:     cfg_q.line_shift     <= cfg_data;
				sactc_pkg::CFG_THRU_MODE:      cfg_q.thru_mode      <= cfg_data[0];
				sactc_pkg::CFG_WRITE_ALLOCATE: cfg_q.write_allocate <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sactc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.line_shift (cfg_q.line_shift),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	sactc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ hw/rtl/sactc_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sactc_checker
// Port-level checks of the cache tag controller.
// ---------------------------------------------------------------------------
module sactc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input sactc_pkg::req_t                  in_data,
	input logic                             out_valid,
	input logic                             out_ready,
	input sactc_pkg::rsp_t                  out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input item changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_hit_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.allocated))
		else $error("hit and allocation together");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit && !out_data.allocated
		|-> out_data.way == '0 && out_data.memory_write)
		else $error("non-allocating miss result malformed");

	a_wb_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.dirty_writeback || out_data.line_fill)
		|-> out_data.allocated)
		else $error("writeback or fill without allocation");

endmodule

bind set_assoc_cache_tag_controller_unit sactc_checker u_sactc_checker (.*);
